// ===== design/ahs_pkg.sv =====
// Package for the annulus search: sizes, codes, chain token and shared types.
`timescale 1ns / 1ps
package ahs_pkg;

    localparam int MAX_PHOTONS = 1024;
    localparam int ADDR_W      = $clog2(MAX_PHOTONS);
    localparam int TOTAL_W     = ADDR_W + 1;
    localparam int COORD_W     = 16;
    localparam int VOTE_W      = 10;
    localparam int RQ_W        = 24;
    localparam int D_W         = 32;
    localparam int SQ_W        = 33;
    localparam int ROOT_W      = 17;
    localparam int NCELLS      = 128;
    localparam int STEP_W      = 7;
    localparam int LEFT_W      = 8;
    localparam int MUL_W       = 8;

    // floor(x/3) for x < 2^17 is (x * 43691) >> 17
    localparam logic [15:0] DIV3_MAGIC = 16'd43691;
    localparam int          DIV3_SHIFT = 17;
    // distance in Q8 times 100
    localparam logic [14:0] D_SCALE    = 15'd25600;

    localparam logic CFG_N_RADII = 1'b0;
    localparam logic CFG_TOL     = 1'b1;

    typedef enum logic [4:0] {
        S_LOAD, S_BOX, S_RADII, S_DIVI, S_DIV, S_SETUP,
        S_CRD, S_CCAP, S_PRD, S_PCAP, S_PSUM, S_PSQ, S_PSCL, S_PINJ,
        S_FIN, S_WAITF, S_WRD, S_WCAP, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        TK_NONE, TK_SETUP, TK_DIST, TK_END, TK_FINAL
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind             kind;
        logic [D_W-1:0]        d;
        logic [RQ_W-1:0]       rq;
        logic [STEP_W-1:0]     frac;
        logic [LEFT_W-1:0]     left;
        logic [ADDR_W-1:0]     idx;
        logic [VOTE_W-1:0]     votes;
    } t_token;

    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic [RQ_W-1:0]   q;
        logic [STEP_W-1:0] rem;
        logic [MUL_W-1:0]  lo_mul;
        logic [MUL_W-1:0]  hi_mul;
        logic              lo_any;
    } t_cell_cfg;

endpackage

// ===== design/ahs_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ahs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/ahs_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module ahs_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ahs_pkg::SQ_W-1:0]   i_val,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [ahs_pkg::ROOT_W-1:0] o_root
);
    import ahs_pkg::*;

    localparam int W = SQ_W + 1;

    logic [W-1:0] r_v, r_res, r_bit;
    logic [4:0]   r_cnt;
    logic         r_busy, r_done;
    logic [W-1:0] w_sum;

    assign w_sum  = r_res + r_bit;
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= {1'b0, i_val};
            r_res <= '0;
            r_bit <= W'(1) << (2 * (ROOT_W - 1));
        end else if (r_busy) begin
            if (r_v >= w_sum) begin
                r_v   <= r_v - w_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end
endmodule

// ===== design/ahs_cell.sv =====
// One radius cell of the vote chain: holds a radius, its counters and its best centre.
`timescale 1ns / 1ps
module ahs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ahs_pkg::t_cell_cfg i_cfg,
    input  ahs_pkg::t_token    i_tok,
    output ahs_pkg::t_token    o_tok
);
    import ahs_pkg::*;

    logic                r_active;
    logic [RQ_W-1:0]     r_rq;
    logic [D_W-1:0]      r_lo, r_hi;
    logic [VOTE_W-1:0]   r_cnt, r_best;
    logic [ADDR_W-1:0]   r_bidx;
    t_token              r_tok;
    t_token              n_tok;

    logic [STEP_W:0]     w_f;
    logic                w_carry;
    logic                w_hit;

    assign w_f     = {1'b0, i_tok.frac} + {1'b0, i_cfg.rem};
    assign w_carry = w_f >= {1'b0, i_cfg.steps};
    assign w_hit   = (i_cfg.lo_any || i_tok.d >= r_lo) && (i_tok.d <= r_hi);
    assign o_tok   = r_tok;

    always_comb begin
        n_tok = i_tok;
        case (i_tok.kind)
            TK_SETUP: begin
                // next radius: step by the quotient, carry from the fraction
                n_tok.rq   = i_tok.rq + i_cfg.q + RQ_W'(w_carry);
                n_tok.frac = w_carry ? STEP_W'(w_f - {1'b0, i_cfg.steps})
                                     : STEP_W'(w_f);
                n_tok.left = (i_tok.left == '0) ? '0 : i_tok.left - LEFT_W'(1);
            end
            TK_FINAL: begin
                if (r_active && r_best > i_tok.votes) begin
                    n_tok.votes = r_best;
                    n_tok.idx   = r_bidx;
                    n_tok.rq    = r_rq;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.kind <= TK_NONE;
            r_active   <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.kind == TK_SETUP) begin
                r_active <= i_tok.left != '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= D_W'(r_rq * i_cfg.lo_mul);
        r_hi <= D_W'(r_rq * i_cfg.hi_mul);
        case (i_tok.kind)
            TK_SETUP: begin
                r_rq   <= i_tok.rq;
                r_cnt  <= '0;
                r_best <= '0;
                r_bidx <= '0;
            end
            TK_DIST: begin
                if (r_active && w_hit) begin
                    r_cnt <= r_cnt + VOTE_W'(1);
                end
            end
            TK_END: begin
                if (r_active && r_cnt > r_best) begin
                    r_best <= r_cnt;
                    r_bidx <= i_tok.idx;
                end
                r_cnt <= '0;
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== design/annulus_hough_search.sv =====
// Top level of the annulus search: photon store, sequencer and radius cell chain.
`timescale 1ns / 1ps
// Usage
//   Photons arrive on the slave stream: tdata = {photon_y, photon_x}, tlast marks the
//   final photon of a set. Loading takes one photon a cycle; up to 1024 are kept,
//   later ones are dropped but a dropped tlast still starts the search.
//   After tlast the block stops taking requests and searches. Every pair of stored
//   photons goes through read, squares, a 17-step bit-serial square root and
//   scaling in turn. Distances then walk a chain of 128 radius cells, one cell a
//   cycle; the winner is collected by a final pass along the chain. One result
//   leaves on the master stream per set:
//   tdata = {votes, radius, y, x}.
//   If the receiver stalls, the result waits in the output register while the next
//   set loads; that set's search then holds at its end until the register is free.
//   Configuration (n_radii at index 0, tolerance_percent at index 1) is written on
//   the plain write port; the user must write it only while the block is idle, as
//   the block itself does not enforce this. Synchronous reset empties the set,
//   restores the register defaults and returns to loading at once; no clearing pass is needed.
module annulus_hough_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // photon_x[15:0], photon_y[31:16]
    input  logic        i_s_tlast,   // last_photon
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // center_x[15:0], center_y[31:16],
                                     // radius_found[47:32], vote_count[57:48]
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [6:0]  i_cfg_wdata
);
    import ahs_pkg::*;

    t_state r_state, n_state;

    logic [STEP_W-1:0]  r_n_radii, r_tol;
    logic [TOTAL_W-1:0] r_total;
    logic [COORD_W-1:0] r_minx, r_maxx, r_miny, r_maxy;
    logic [COORD_W-1:0] n_minx, n_maxx, n_miny, n_maxy;
    logic [COORD_W-1:0] r_m, r_minr, r_maxr;
    logic [33:0]        r_prod;
    logic [RQ_W-1:0]    r_dq;
    logic [STEP_W-1:0]  r_drem;
    logic [4:0]         r_dcnt;
    logic [TOTAL_W-1:0] r_i, r_j;
    logic [COORD_W-1:0] r_cx, r_cy;
    logic [31:0]        r_sqx, r_sqy;
    logic [D_W-1:0]     r_d;
    logic [VOTE_W-1:0]  r_wvotes;
    logic [ADDR_W-1:0]  r_widx;
    logic [RQ_W-1:0]    r_wrq;
    logic [COORD_W-1:0] r_fx, r_fy;
    logic               r_out_valid;
    logic [63:0]        r_out;

    logic               w_accept, w_store;
    logic [COORD_W-1:0] w_px, w_py, w_h, w_w, w_ax, w_ay, w_diff;
    logic [STEP_W-1:0]  w_steps;
    logic [STEP_W:0]    w_dtry;
    logic [ADDR_W-1:0]  w_raddr;
    logic [COORD_W-1:0] w_rdx, w_rdy;
    logic               w_sq_start, w_sq_busy, w_sq_done;
    logic [ROOT_W-1:0]  w_root;
    logic               w_out_load;
    t_token             w_inj;
    t_cell_cfg          w_ccfg;
    t_token             w_tok [NCELLS+1];

    assign w_px     = i_s_tdata[COORD_W-1:0];
    assign w_py     = i_s_tdata[2*COORD_W-1:COORD_W];
    assign o_s_tready = (r_state == S_LOAD);
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_store  = w_accept && (r_total < TOTAL_W'(MAX_PHOTONS));
    assign w_h      = r_maxy - r_miny;
    assign w_w      = r_maxx - r_minx;
    assign w_ax     = (w_rdx > r_cx) ? w_rdx - r_cx : r_cx - w_rdx;
    assign w_ay     = (w_rdy > r_cy) ? w_rdy - r_cy : r_cy - w_rdy;
    assign w_diff   = r_prod[DIV3_SHIFT+COORD_W-1:DIV3_SHIFT] - r_minr;
    assign w_steps  = (r_n_radii == '0) ? STEP_W'(1) : r_n_radii;
    assign w_dtry   = {r_drem, r_dq[RQ_W-1]};
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    assign n_minx = (w_px < r_minx) ? w_px : r_minx;
    assign n_maxx = (w_px > r_maxx) ? w_px : r_maxx;
    assign n_miny = (w_py < r_miny) ? w_py : r_miny;
    assign n_maxy = (w_py > r_maxy) ? w_py : r_maxy;

    always_comb begin
        w_ccfg.steps  = w_steps;
        w_ccfg.q      = r_dq;
        w_ccfg.rem    = r_drem;
        w_ccfg.lo_any = r_tol >= STEP_W'(100);
        w_ccfg.lo_mul = w_ccfg.lo_any ? '0 : MUL_W'(8'd100 - {1'b0, r_tol});
        w_ccfg.hi_mul = MUL_W'(8'd100 + {1'b0, r_tol});
    end

    ahs_ram #(.WIDTH(COORD_W), .DEPTH(MAX_PHOTONS)) u_xram (
        .i_clk(i_clk), .i_we(w_store), .i_waddr(r_total[ADDR_W-1:0]),
        .i_wdata(w_px), .i_raddr(w_raddr), .o_rdata(w_rdx)
    );
    ahs_ram #(.WIDTH(COORD_W), .DEPTH(MAX_PHOTONS)) u_yram (
        .i_clk(i_clk), .i_we(w_store), .i_waddr(r_total[ADDR_W-1:0]),
        .i_wdata(w_py), .i_raddr(w_raddr), .o_rdata(w_rdy)
    );

    ahs_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
        .i_val(SQ_W'(r_sqx) + SQ_W'(r_sqy)),
        .o_busy(w_sq_busy), .o_done(w_sq_done), .o_root(w_root)
    );

    assign w_tok[0] = w_inj;
    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        ahs_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_ccfg),
            .i_tok(w_tok[k]), .o_tok(w_tok[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_raddr    = r_j[ADDR_W-1:0];
        w_sq_start = 1'b0;
        w_inj      = '0;
        w_inj.kind = TK_NONE;
        case (r_state)
            S_LOAD:  if (w_accept && i_s_tlast) n_state = S_BOX;
            S_BOX:   n_state = S_RADII;
            S_RADII: n_state = S_DIVI;
            S_DIVI:  n_state = S_DIV;
            S_DIV:   if (r_dcnt == 5'd1) n_state = S_SETUP;
            S_SETUP: begin
                w_inj.kind = TK_SETUP;
                w_inj.rq   = {r_minr, 8'd0};
                w_inj.left = (r_minr == r_maxr) ? LEFT_W'(1)
                                                : LEFT_W'({1'b0, w_steps} + 8'd1);
                n_state    = S_CRD;
            end
            S_CRD: begin
                w_raddr = r_i[ADDR_W-1:0];
                n_state = S_CCAP;
            end
            S_CCAP: n_state = S_PRD;
            S_PRD: begin
                if (r_j == r_total) begin
                    w_inj.kind = TK_END;
                    w_inj.idx  = r_i[ADDR_W-1:0];
                    n_state    = (r_i + TOTAL_W'(1) == r_total) ? S_FIN : S_CRD;
                end else if (r_j != r_i) begin
                    n_state = S_PCAP;
                end
            end
            S_PCAP: n_state = S_PSUM;
            S_PSUM: begin
                w_sq_start = 1'b1;
                n_state    = S_PSQ;
            end
            S_PSQ:  if (w_sq_done) n_state = S_PSCL;
            S_PSCL: n_state = S_PINJ;
            S_PINJ: begin
                w_inj.kind = TK_DIST;
                w_inj.d    = r_d;
                n_state    = S_PRD;
            end
            S_FIN: begin
                w_inj.kind = TK_FINAL;
                n_state    = S_WAITF;
            end
            S_WAITF: begin
                if (w_tok[NCELLS].kind == TK_FINAL) begin
                    n_state = (w_tok[NCELLS].votes == '0) ? S_OUT : S_WRD;
                end
            end
            S_WRD: begin
                w_raddr = r_widx;
                n_state = S_WCAP;
            end
            S_WCAP: n_state = S_OUT;
            S_OUT:  if (w_out_load) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_radii   <= STEP_W'(20);
            r_tol       <= STEP_W'(30);
            r_total     <= '0;
            r_minx      <= '1;
            r_miny      <= '1;
            r_maxx      <= '0;
            r_maxy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_N_RADII: r_n_radii <= i_cfg_wdata;
                    CFG_TOL:     r_tol     <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (w_store) begin
                r_total <= r_total + TOTAL_W'(1);
                r_minx  <= n_minx;
                r_maxx  <= n_maxx;
                r_miny  <= n_miny;
                r_maxy  <= n_maxy;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_total     <= '0;
                r_minx      <= '1;
                r_miny      <= '1;
                r_maxx      <= '0;
                r_maxy      <= '0;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_BOX:   r_m <= (w_h < w_w) ? w_h : w_w;
            S_RADII: begin
                r_minr <= r_m >> 2;
                r_prod <= 34'({r_m, 1'b0} * DIV3_MAGIC);
            end
            S_DIVI: begin
                r_maxr <= r_prod[DIV3_SHIFT+COORD_W-1:DIV3_SHIFT];
                r_dq   <= {w_diff, 8'd0};
                r_drem <= '0;
                r_dcnt <= 5'(RQ_W);
            end
            S_DIV: begin
                // restoring division of the radius span by the step count
                if (w_dtry >= {1'b0, w_steps}) begin
                    r_drem <= STEP_W'(w_dtry - {1'b0, w_steps});
                    r_dq   <= {r_dq[RQ_W-2:0], 1'b1};
                end else begin
                    r_drem <= STEP_W'(w_dtry);
                    r_dq   <= {r_dq[RQ_W-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 5'd1;
            end
            S_SETUP: r_i <= '0;
            S_CCAP: begin
                r_cx <= w_rdx;
                r_cy <= w_rdy;
                r_j  <= '0;
            end
            S_PRD: begin
                if (r_j == r_total) begin
                    r_i <= r_i + TOTAL_W'(1);
                end else if (r_j == r_i) begin
                    r_j <= r_j + TOTAL_W'(1);
                end
            end
            S_PCAP: begin
                r_sqx <= w_ax * w_ax;
                r_sqy <= w_ay * w_ay;
            end
            S_PSCL: r_d <= D_W'(w_root * D_SCALE);
            S_PINJ: r_j <= r_j + TOTAL_W'(1);
            S_WAITF: begin
                r_wvotes <= w_tok[NCELLS].votes;
                r_widx   <= w_tok[NCELLS].idx;
                r_wrq    <= w_tok[NCELLS].rq;
                r_fx     <= '0;
                r_fy     <= '0;
            end
            S_WCAP: begin
                r_fx <= w_rdx;
                r_fy <= w_rdy;
            end
            S_OUT: begin
                if (w_out_load) begin
                    r_out <= {6'd0, r_wvotes, r_wrq[RQ_W-1:8], r_fy, r_fx};
                end
            end
            default: begin
            end
        endcase
    end

    a_final_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[NCELLS].kind == TK_FINAL |-> r_state == S_WAITF)
        else $error("final token left chain outside wait state");

    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOTAL_W'(MAX_PHOTONS))
        else $error("photon count beyond store depth");

    a_sqrt_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_start |-> !w_sq_busy)
        else $error("square root started while busy");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> r_out_valid && r_total == '0)
        else $error("result not posted or set not cleared");
endmodule
